@@ hdl/surface_texture_coordinate_unit_assert.svh @@
// assertion macros for the surface texture coordinate unit
`ifndef SURFACE_TEXTURE_COORDINATE_UNIT_ASSERT_SVH
`define SURFACE_TEXTURE_COORDINATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define STC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stc assertion failed");
// next-cycle implication
`define STC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stc assertion failed");
`else
`define STC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define STC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/stc_pkg.sv @@
// shared types and constants of the surface texture coordinate unit
package stc_pkg;

  typedef enum logic {
    OP_SPHERE = 1'b0,
    OP_PLANE  = 1'b1
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic        [30:0] radius;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } out_item_t;

  // difference width, cordic datapath width, binary angle width
  localparam int IW = 33;
  localparam int XW = 62;
  localparam int ZW = 34;
  // normalized magnitude lands in [2^NORM_MSB, 2^(NORM_MSB+1))
  localparam int NORM_MSB = 56;
  localparam int NORM_STEPS = 6;
  localparam int SQRT_STEPS = 32;
  localparam int MAX_STAGES = 32;

  // pi in binary angle units
  localparam logic signed [ZW-1:0] ANG_PI = 34'sh080000000;

  // atan(2^-i), full circle = 2^32
  localparam logic [29:0] ATAN_TAB [MAX_STAGES] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

endpackage

@@ hdl/stc_chan_if.sv @@
// valid/ready channel carrying one payload beat
interface stc_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/surface_texture_coordinate_unit.sv @@
// top level: sphere and plane texture coordinates; one hit per cycle unless stalled
// throughput: one beat per cycle, set by the row of cordic, sqrt and normalize cells
// a stalled output stalls the whole row only when its last stage holds a result
// reset: asynchronous active low, clears valid flags only; no clearing pass
module surface_texture_coordinate_unit #(
  parameter int FRAC_BITS = 16,
  parameter int CORDIC_STAGES = 20
) (
  input logic       clk_i,
  input logic       rst_ni,
  stc_chan_if.sink   in_i,
  stc_chan_if.source out_o
);
  `include "surface_texture_coordinate_unit_assert.svh"

  localparam int IW = stc_pkg::IW;
  localparam int ZW = stc_pkg::ZW;
  localparam int NR = 5;                        // radius normalize steps
  localparam int T_NORM = 1 + NR;               // radius normalized
  localparam int T_SQ = T_NORM + 2 + stc_pkg::SQRT_STEPS;  // sqrt done
  localparam int LU = 1 + stc_pkg::NORM_STEPS + CORDIC_STAGES;  // atan2 latency
  localparam int LAT = T_SQ + LU;               // last pipeline stage
  localparam int T_PL = 6;                      // plane result ready
  localparam int AXW = 68;
  localparam int AYW = 101;

  typedef struct packed {
    logic dy_zero;
    logic dy_sat;
    logic dy_pos;
  } sph_flags_t;
  typedef logic signed [IW-1:0] dval_t;
  typedef logic signed [ZW-1:0] ang_t;

  localparam logic signed [AXW-1:0] AX_HALF = AXW'(1) << (FRAC_BITS - 1);
  localparam logic signed [AYW-1:0] AY_HALF = AYW'(1) << (2 * FRAC_BITS - 1);
  localparam logic signed [AXW-1:0] AX_MAX = AXW'(64'sd2147483647);
  localparam logic signed [AXW-1:0] AX_MIN = AXW'(-64'sd2147483648);
  localparam logic signed [AYW-1:0] AY_MAX = AYW'(64'sd2147483647);
  localparam logic signed [AYW-1:0] AY_MIN = AYW'(-64'sd2147483648);
  localparam logic signed [ZW-1:0] U_RND = ZW'(1) << (31 - FRAC_BITS);
  localparam logic signed [ZW-1:0] V_RND = ZW'(1) << (30 - FRAC_BITS);
  localparam logic [31:0] TEX_ONE = 32'(1) << FRAC_BITS;

  // ---------------------------------------------------------------- flow control
  // the row advances together; a bubble in the last stage never blocks it
  logic [LAT:0] vld_q;
  logic         ovld_q;
  logic         adv, in_fire, ld_out;
  stc_pkg::out_item_t odata_q, fin_data;

  assign adv = out_o.ready || !ovld_q || !vld_q[LAT];
  assign in_i.ready = adv;
  assign in_fire = in_i.valid && adv;
  assign ld_out = vld_q[LAT] && (out_o.ready || !ovld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[LAT-1:0], in_fire};
      end
      if (ld_out) begin
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      odata_q <= fin_data;
    end
  end

  assign out_o.valid = ovld_q;
  assign out_o.data = odata_q;

  // ---------------------------------------------------------------- input stage
  // exact 33-bit offsets from the origin
  stc_pkg::op_e       s0_op_q;
  dval_t              s0_d_q [3];
  logic signed [31:0] s0_n_q [3];
  logic [30:0]        s0_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_op_q <= in_i.data.operation;
      s0_d_q[0] <= dval_t'(in_i.data.hit_x) - dval_t'(in_i.data.origin_x);
      s0_d_q[1] <= dval_t'(in_i.data.hit_y) - dval_t'(in_i.data.origin_y);
      s0_d_q[2] <= dval_t'(in_i.data.hit_z) - dval_t'(in_i.data.origin_z);
      s0_n_q[0] <= in_i.data.normal_x;
      s0_n_q[1] <= in_i.data.normal_y;
      s0_n_q[2] <= in_i.data.normal_z;
      s0_r_q <= in_i.data.radius;
    end
  end

  // ---------------------------------------------------------------- sphere u
  // longitude from atan2(dz, dx), then held until the v path catches up
  ang_t zu, zu_end;

  stc_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_u (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (s0_d_q[0]),
    .y_i   (s0_d_q[2]),
    .z_o   (zu)
  );

  stc_delay #(.T(ang_t), .DEPTH(T_SQ)) u_dly_zu (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (zu),
    .q_o   (zu_end)
  );

  // ---------------------------------------------------------------- sphere v
  // classify dy against the radius; only the inner case needs the angle
  sph_flags_t s1_flg_q, flg_end;
  dval_t      dy_abs;
  dval_t      dn_q [NR+1];
  logic [30:0] rn_q [NR+1];

  assign dy_abs = s0_d_q[1][IW-1] ? -s0_d_q[1] : s0_d_q[1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_flg_q.dy_zero <= (s0_d_q[1] == '0);
      s1_flg_q.dy_sat <= (dy_abs >= {2'b00, s0_r_q});
      s1_flg_q.dy_pos <= (s0_d_q[1] > 0);
      dn_q[0] <= s0_d_q[1];
      rn_q[0] <= s0_r_q;
    end
  end

  // scale radius into [2^30, 2^31), dy along with it
  for (genvar g = 0; g < NR; g++) begin : g_rnorm
    localparam int K = 16 >> g;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rn_q[g][30:31-K] == '0) begin
          rn_q[g+1] <= rn_q[g] << K;
          dn_q[g+1] <= dn_q[g] <<< K;
        end else begin
          rn_q[g+1] <= rn_q[g];
          dn_q[g+1] <= dn_q[g];
        end
      end
    end
  end

  // r^2 - dy^2, one multiplier per term
  logic [61:0] rr_q, dd_q, diff_q;
  logic signed [2*IW-1:0] dy_sq;

  assign dy_sq = dn_q[NR] * dn_q[NR];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rr_q <= rn_q[NR] * rn_q[NR];
      dd_q <= dy_sq[61:0];
      diff_q <= rr_q - dd_q;
    end
  end

  // floor square root, one result bit per cell
  logic [63:0] sq_rem [stc_pkg::SQRT_STEPS+1];
  logic [63:0] sq_root [stc_pkg::SQRT_STEPS+1];

  assign sq_rem[0] = {2'b00, diff_q};
  assign sq_root[0] = '0;

  for (genvar i = 0; i < stc_pkg::SQRT_STEPS; i++) begin : g_sqrt
    stc_sqrt_cell #(.IDX(i)) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  dval_t dy_sq_end;
  ang_t  zv;

  stc_delay #(.T(dval_t), .DEPTH(T_SQ - T_NORM)) u_dly_dy (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (dn_q[NR]),
    .q_o   (dy_sq_end)
  );

  // colatitude = atan2(sqrt(r^2 - dy^2), dy)
  stc_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_v (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (dy_sq_end),
    .y_i   ({2'b00, sq_root[stc_pkg::SQRT_STEPS][30:0]}),
    .z_o   (zv)
  );

  stc_delay #(.T(sph_flags_t), .DEPTH(LAT - 1)) u_dly_flg (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (s1_flg_q),
    .q_o   (flg_end)
  );

  // ---------------------------------------------------------------- plane
  // x axis from the normal, then ay = sum d_i * (n x xa)_i
  logic signed [IW-1:0] xa [3];
  logic                 xa_sel;

  assign xa_sel = (s0_n_q[0] != '0) || (s0_n_q[1] != '0);
  assign xa[0] = xa_sel ? IW'(s0_n_q[1]) : -IW'(s0_n_q[2]);
  assign xa[1] = xa_sel ? -IW'(s0_n_q[0]) : '0;
  assign xa[2] = xa_sel ? '0 : IW'(s0_n_q[0]);

  logic signed [2*IW-1:0] p1_dx_q [3];
  logic signed [64:0]     p1_c1_q [3];
  logic signed [64:0]     p1_c2_q [3];
  dval_t                  p1_d_q [3];
  logic signed [AXW-1:0]  ax_q [4];
  logic signed [65:0]     p2_c_q [3];
  dval_t                  p2_d_q [3];
  logic signed [65:0]     p3_lo_q [3];
  logic signed [66:0]     p3_hi_q [3];
  logic signed [AYW-1:0]  p4_t_q [3];
  logic signed [AYW-1:0]  ay_q;
  stc_pkg::out_item_t     pl_q, pl_end;

  // round half up, then clamp to 32-bit signed
  stc_pkg::out_item_t    pl_rnd;
  logic signed [AXW-1:0] ax_sum, ax_sh;
  logic signed [AYW-1:0] ay_sum, ay_sh;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_dx_q[i] <= s0_d_q[i] * xa[i];
        p1_c1_q[i] <= s0_n_q[(i+1)%3] * xa[(i+2)%3];
        p1_c2_q[i] <= s0_n_q[(i+2)%3] * xa[(i+1)%3];
        p1_d_q[i] <= s0_d_q[i];
        p2_c_q[i] <= 66'(p1_c1_q[i]) - 66'(p1_c2_q[i]);
        p2_d_q[i] <= p1_d_q[i];
        // split the 66-bit factor so each product stays near 33 x 33
        p3_lo_q[i] <= p2_d_q[i] * $signed({1'b0, p2_c_q[i][31:0]});
        p3_hi_q[i] <= p2_d_q[i] * $signed(p2_c_q[i][65:32]);
        p4_t_q[i] <= (AYW'(p3_hi_q[i]) <<< 32) + AYW'(p3_lo_q[i]);
      end
      ax_q[0] <= AXW'(p1_dx_q[0]) + AXW'(p1_dx_q[1]) + AXW'(p1_dx_q[2]);
      ax_q[1] <= ax_q[0];
      ax_q[2] <= ax_q[1];
      ax_q[3] <= ax_q[2];
      ay_q <= p4_t_q[0] + p4_t_q[1] + p4_t_q[2];
      pl_q <= pl_rnd;
    end
  end

  always_comb begin
    ax_sum = ax_q[3] + AX_HALF;
    ax_sh = ax_sum >>> FRAC_BITS;
    ay_sum = ay_q + AY_HALF;
    ay_sh = ay_sum >>> (2 * FRAC_BITS);
    if (ax_sh > AX_MAX) begin
      pl_rnd.tex_u = AX_MAX[31:0];
    end else if (ax_sh < AX_MIN) begin
      pl_rnd.tex_u = AX_MIN[31:0];
    end else begin
      pl_rnd.tex_u = ax_sh[31:0];
    end
    if (ay_sh > AY_MAX) begin
      pl_rnd.tex_v = AY_MAX[31:0];
    end else if (ay_sh < AY_MIN) begin
      pl_rnd.tex_v = AY_MIN[31:0];
    end else begin
      pl_rnd.tex_v = ay_sh[31:0];
    end
  end

  stc_delay #(.T(stc_pkg::out_item_t), .DEPTH(LAT - T_PL)) u_dly_pl (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (pl_q),
    .q_o   (pl_end)
  );

  stc_pkg::op_e op_end;

  stc_delay #(.T(stc_pkg::op_e), .DEPTH(LAT)) u_dly_op (
    .clk_i (clk_i),
    .en_i  (adv),
    .d_i   (s0_op_q),
    .q_o   (op_end)
  );

  // ---------------------------------------------------------------- final stage
  // clamp the angles and scale them into the texture range
  ang_t        zu_c, zv_sel;
  logic [ZW-1:0] u_tmp, v_tmp, u_sh, v_sh;
  logic [31:0] u_sph, v_sph;

  always_comb begin
    if (zu_end < -stc_pkg::ANG_PI) begin
      zu_c = -stc_pkg::ANG_PI;
    end else if (zu_end > stc_pkg::ANG_PI) begin
      zu_c = stc_pkg::ANG_PI;
    end else begin
      zu_c = zu_end;
    end

    if (flg_end.dy_zero) begin
      zv_sel = stc_pkg::ANG_PI >>> 1;
    end else if (flg_end.dy_sat) begin
      zv_sel = flg_end.dy_pos ? '0 : stc_pkg::ANG_PI;
    end else if (zv < 0) begin
      zv_sel = '0;
    end else if (zv > stc_pkg::ANG_PI) begin
      zv_sel = stc_pkg::ANG_PI;
    end else begin
      zv_sel = zv;
    end

    u_tmp = zu_c + stc_pkg::ANG_PI + U_RND;
    v_tmp = zv_sel + V_RND;
    u_sh = u_tmp >> (32 - FRAC_BITS);
    v_sh = v_tmp >> (31 - FRAC_BITS);
    u_sph = u_sh[31:0];
    v_sph = v_sh[31:0];

    if (op_end == stc_pkg::OP_PLANE) begin
      fin_data = pl_end;
    end else begin
      fin_data.tex_u = u_sph;
      fin_data.tex_v = v_sph;
    end
  end

  // ---------------------------------------------------------------- checks
  `STC_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, in_i.valid && in_i.ready, vld_q[0])
  `STC_ASSERT_NXT(a_tail_held, clk_i, rst_ni, vld_q[LAT] && !adv, vld_q[LAT])
  `STC_ASSERT_IMP(a_sph_u_range, clk_i, rst_ni, ld_out && op_end == stc_pkg::OP_SPHERE, u_sph <= TEX_ONE)
  `STC_ASSERT_IMP(a_sph_v_range, clk_i, rst_ni, ld_out && op_end == stc_pkg::OP_SPHERE, v_sph <= TEX_ONE)
endmodule

@@ hdl/stc_cordic_cell.sv @@
// one vectoring cordic rotation step, registered
module stc_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [stc_pkg::XW-1:0]  x_i,
  input  logic signed [stc_pkg::XW-1:0]  y_i,
  input  logic signed [stc_pkg::ZW-1:0]  z_i,
  output logic signed [stc_pkg::XW-1:0]  x_o,
  output logic signed [stc_pkg::XW-1:0]  y_o,
  output logic signed [stc_pkg::ZW-1:0]  z_o
);
  logic signed [stc_pkg::XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [stc_pkg::ZW-1:0] ang, z_d, z_q;

  assign ang = {{(stc_pkg::ZW-30){1'b0}}, stc_pkg::ATAN_TAB[IDX]};

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    x_d = x_i;
    y_d = y_i;
    z_d = z_i;
    if (y_i > 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ang;
    end else if (y_i < 0) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule

@@ hdl/stc_sqrt_cell.sv @@
// one digit step of the integer square root, registered
module stc_sqrt_cell #(
  parameter int IDX = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rem_i,
  input  logic [63:0] root_i,
  output logic [63:0] rem_o,
  output logic [63:0] root_o
);
  localparam logic [63:0] Bit = 64'(1) << (62 - 2 * IDX);

  logic [63:0] trial, rem_d, root_d, rem_q, root_q;

  always_comb begin
    trial = root_i + Bit;
    if (rem_i >= trial) begin
      rem_d = rem_i - trial;
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o = rem_q;
  assign root_o = root_q;
endmodule

@@ hdl/stc_delay.sv @@
// fixed-length delay line with shared advance
module stc_delay #(
  parameter type T = logic,
  parameter int DEPTH = 1
) (
  input  logic clk_i,
  input  logic en_i,
  input  T     d_i,
  output T     q_o
);
  T pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[DEPTH-1];
endmodule

@@ hdl/stc_atan2.sv @@
// pipelined atan2: quadrant fold, normalizing shifts, cordic cell row
module stc_atan2 #(
  parameter int STAGES = 20
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [stc_pkg::IW-1:0]  x_i,
  input  logic signed [stc_pkg::IW-1:0]  y_i,
  output logic signed [stc_pkg::ZW-1:0]  z_o
);
  localparam int XW = stc_pkg::XW;
  localparam int ZW = stc_pkg::ZW;
  localparam int IW = stc_pkg::IW;
  localparam int NS = stc_pkg::NORM_STEPS;

  logic signed [XW-1:0] xe, ye, xp, yp, ya;
  logic signed [ZW-1:0] z0;
  logic        [XW-1:0] m0;

  logic signed [XW-1:0] nx_q [NS+1];
  logic signed [XW-1:0] ny_q [NS+1];
  logic        [XW-1:0] nm_q [NS+1];
  logic signed [ZW-1:0] nz_q [NS+1];

  logic signed [XW-1:0] cx [STAGES+1];
  logic signed [XW-1:0] cy [STAGES+1];
  logic signed [ZW-1:0] cz [STAGES+1];

  // fold left half plane onto the right one
  always_comb begin
    xe = {{(XW-IW){x_i[IW-1]}}, x_i};
    ye = {{(XW-IW){y_i[IW-1]}}, y_i};
    if (xe < 0) begin
      xp = -xe;
      yp = -ye;
      z0 = (ye < 0) ? -stc_pkg::ANG_PI : stc_pkg::ANG_PI;
    end else begin
      xp = xe;
      yp = ye;
      z0 = '0;
    end
    ya = (yp < 0) ? -yp : yp;
    m0 = (ya > xp) ? ya : xp;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q[0] <= xp;
      ny_q[0] <= yp;
      nm_q[0] <= m0;
      nz_q[0] <= z0;
    end
  end

  // binary search of the left shift, largest step first
  for (genvar g = 0; g < NS; g++) begin : g_norm
    localparam int K = 32 >> g;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nz_q[g+1] <= nz_q[g];
        if (nm_q[g][XW-1:stc_pkg::NORM_MSB+1-K] == '0) begin
          nx_q[g+1] <= nx_q[g] <<< K;
          ny_q[g+1] <= ny_q[g] <<< K;
          nm_q[g+1] <= nm_q[g] << K;
        end else begin
          nx_q[g+1] <= nx_q[g];
          ny_q[g+1] <= ny_q[g];
          nm_q[g+1] <= nm_q[g];
        end
      end
    end
  end

  assign cx[0] = nx_q[NS];
  assign cy[0] = ny_q[NS];
  assign cz[0] = nz_q[NS];

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    stc_cordic_cell #(.IDX(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  assign z_o = cz[STAGES];
endmodule

@@ test/tb_top.sv @@
// testbench for the surface texture coordinate unit: uv prediction, random gaps and stalls
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // the dut runs at its default parameters
  localparam int FRAC = 16;
  localparam int STAGES = 20;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint CYCLE_LIMIT = 400000;

  typedef logic signed [127:0] wide_t;

  logic clk_i;
  logic rst_ni;

  stc_chan_if #(.T(stc_pkg::in_item_t))  hit_ch ();
  stc_chan_if #(.T(stc_pkg::out_item_t)) uv_ch ();

  surface_texture_coordinate_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (hit_ch),
    .out_o (uv_ch)
  );

  // expected uv pairs, oldest first
  stc_pkg::out_item_t uv_expected[$];
  int        mismatch_count;
  longint    cycle_count;
  bit        no_gaps;  // when set, neither side idles

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // vectoring cordic, returns a binary angle where pi is 2^31
  function automatic longint cordic_angle(longint y, longint x);
    longint z, m, ay, xs, ys;
    z = 0;
    // left half plane: rotate by pi first
    if (x < 0) begin
      z = (y < 0) ? -HALF_TURN : HALF_TURN;
      x = -x;
      y = -y;
    end
    if (x == 0 && y == 0) return z;
    ay = (y < 0) ? -y : y;
    m  = (x > ay) ? x : ay;
    // normalize so the larger magnitude has its msb at bit 56
    while (m < (64'sd1 <<< 56)) begin
      m = m * 2;
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(stc_pkg::ATAN_TAB[i]);
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(stc_pkg::ATAN_TAB[i]);
      end else begin
        break;
      end
    end
    return z;
  endfunction

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // round half up by s bits, then clamp to 32-bit signed
  function automatic logic [31:0] round_clamp(wide_t a, int s);
    wide_t t;
    t = (a + (wide_t'(1) <<< (s - 1))) >>> s;
    if (t > 128'sd2147483647) return 32'h7fffffff;
    if (t < -128'sd2147483648) return 32'h80000000;
    return t[31:0];
  endfunction

  function automatic stc_pkg::out_item_t predict_uv(stc_pkg::in_item_t it);
    stc_pkg::out_item_t res;
    longint d[3], n[3], ax_v[3];
    longint rad, dy, zu, zv, ady;
    longint unsigned root;
    wide_t acc_u, acc_v;
    int j, k;
    d[0] = longint'(it.hit_x) - longint'(it.origin_x);
    d[1] = longint'(it.hit_y) - longint'(it.origin_y);
    d[2] = longint'(it.hit_z) - longint'(it.origin_z);
    n[0] = longint'(it.normal_x);
    n[1] = longint'(it.normal_y);
    n[2] = longint'(it.normal_z);
    if (it.operation == stc_pkg::OP_SPHERE) begin
      rad = longint'(it.radius);
      dy  = d[1];
      zu  = cordic_angle(d[2], d[0]);
      if (zu < -HALF_TURN) zu = -HALF_TURN;
      if (zu > HALF_TURN) zu = HALF_TURN;
      ady = (dy < 0) ? -dy : dy;
      if (dy == 0) begin
        // acos(0): equator
        zv = HALF_TURN / 2;
      end else if (ady >= rad) begin
        // argument saturates to +-1, zero radius with nonzero dy lands here too
        zv = (dy > 0) ? 0 : HALF_TURN;
      end else begin
        while (rad < (64'sd1 <<< 30)) begin
          rad = rad * 2;
          dy  = dy * 2;
        end
        root = int_sqrt(longint'(rad * rad) - longint'(dy * dy));
        zv = cordic_angle(longint'(root), dy);
      end
      if (zv < 0) zv = 0;
      if (zv > HALF_TURN) zv = HALF_TURN;
      res.tex_u = 32'((zu + HALF_TURN + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC));
      res.tex_v = 32'((zv + (64'sd1 <<< (30 - FRAC))) >>> (31 - FRAC));
    end else begin
      // x axis is normal x z, or normal x y when normal lies on z
      if (n[0] != 0 || n[1] != 0) begin
        ax_v[0] = n[1];
        ax_v[1] = -n[0];
        ax_v[2] = 0;
      end else begin
        ax_v[0] = -n[2];
        ax_v[1] = 0;
        ax_v[2] = n[0];
      end
      acc_u = '0;
      acc_v = '0;
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        acc_u = acc_u + wide_t'(d[i]) * wide_t'(ax_v[i]);
        acc_v = acc_v + wide_t'(d[i] * n[j]) * wide_t'(ax_v[k]);
        acc_v = acc_v - wide_t'(d[i] * n[k]) * wide_t'(ax_v[j]);
      end
      res.tex_u = round_clamp(acc_u, FRAC);
      res.tex_v = round_clamp(acc_v, 2 * FRAC);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // hit side
  // ---------------------------------------------------------------------------

  // sends one hit beat; valid stays high afterwards so back to back beats need no toggle
  task automatic send_hit(stc_pkg::in_item_t it);
    int gap;
    bit taken;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      hit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    hit_ch.valid <= 1'b1;
    hit_ch.data  <= it;
    // ready sampled mid cycle, beat taken at the following edge
    forever begin
      @(negedge clk_i);
      taken = hit_ch.ready;
      @(posedge clk_i);
      if (taken) break;
    end
    uv_expected.push_back(predict_uv(it));
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, compare each beat with the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : uv_sink
    int stall;
    bit fire;
    stc_pkg::out_item_t got, want;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        uv_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      uv_ch.ready <= 1'b1;
      forever begin
        @(negedge clk_i);
        fire = uv_ch.valid;
        got  = uv_ch.data;
        @(posedge clk_i);
        if (fire) break;
      end
      if (uv_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected uv beat: u=%h v=%h", got.tex_u, got.tex_v);
      end else begin
        want = uv_expected.pop_front();
        if (got.tex_u !== want.tex_u || got.tex_v !== want.tex_v) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("uv mismatch: expected u=%h v=%h, got u=%h v=%h",
                     want.tex_u, want.tex_v, got.tex_u, got.tex_v);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // coordinate with a random scale so all bits toggle yet small offsets are common
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh0001ffff);
      2: return 32'($signed($urandom_range(0, 32'h07ffffff)) - 32'sh03ffffff);
      default: return $urandom_range(0, 4) - 2;
    endcase
  endfunction

  function automatic stc_pkg::in_item_t make_hit(stc_pkg::op_e op, logic [31:0] hx,
                                                 logic [31:0] hy, logic [31:0] hz,
                                                 logic [31:0] ox, logic [31:0] oy,
                                                 logic [31:0] oz, logic [30:0] rad,
                                                 logic [31:0] nx, logic [31:0] ny,
                                                 logic [31:0] nz);
    stc_pkg::in_item_t it;
    it.operation = op;
    it.hit_x = hx;  it.hit_y = hy;  it.hit_z = hz;
    it.origin_x = ox; it.origin_y = oy; it.origin_z = oz;
    it.radius = rad;
    it.normal_x = nx; it.normal_y = ny; it.normal_z = nz;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_sphere_corners();
    // dx and dz both zero: u is one half
    send_hit(make_hit(stc_pkg::OP_SPHERE, 0, 32'h00010000, 0, 0, 0, 0, 31'h00020000,
                      $urandom, $urandom, $urandom));
    // dx negative with dz zero: u is one
    send_hit(make_hit(stc_pkg::OP_SPHERE, 32'hffff0000, 32'h00008000, 0, 0, 0, 0,
                      31'h00020000, 0, 0, 0));
    // dy zero: v is one half
    send_hit(make_hit(stc_pkg::OP_SPHERE, 32'h00030000, 0, 32'h00010000, 0, 0, 0,
                      31'h00040000, 0, 0, 0));
    // dy at or beyond radius, both signs
    send_hit(make_hit(stc_pkg::OP_SPHERE, 0, 32'h00050000, 32'h00010000, 0, 0, 0,
                      31'h00050000, 0, 0, 0));
    send_hit(make_hit(stc_pkg::OP_SPHERE, 32'h00010000, 32'hfff00000, 0, 0, 0, 0,
                      31'h00050000, 0, 0, 0));
    // zero radius, dy of either sign and zero
    send_hit(make_hit(stc_pkg::OP_SPHERE, 1, 1, 1, 0, 0, 0, 31'd0, 0, 0, 0));
    send_hit(make_hit(stc_pkg::OP_SPHERE, 1, 32'hffffffff, 1, 0, 0, 0, 31'd0, 0, 0, 0));
    send_hit(make_hit(stc_pkg::OP_SPHERE, 1, 0, 1, 0, 0, 0, 31'd0, 0, 0, 0));
    // extreme differences and the largest radius
    send_hit(make_hit(stc_pkg::OP_SPHERE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff, 0, 0, 0));
    send_hit(make_hit(stc_pkg::OP_SPHERE, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff,
                      32'hffffffff, 32'hffffffff, 32'hffffffff));
    // interior point with a tiny radius and a tiny offset
    send_hit(make_hit(stc_pkg::OP_SPHERE, 3, 1, 32'hfffffffd, 0, 0, 0, 31'd2, 0, 0, 0));
    send_hit(make_hit(stc_pkg::OP_SPHERE, 32'h00008000, 32'hffffc000, 32'h00008000,
                      0, 0, 0, 31'h00010000, 0, 0, 0));
  endtask

  task automatic test_plane_corners();
    // normal of all zeros: result is zero
    send_hit(make_hit(stc_pkg::OP_PLANE, $urandom, $urandom, $urandom, 0, 0, 0,
                      31'($urandom), 0, 0, 0));
    // normal on the z axis: x axis falls back to normal x y
    send_hit(make_hit(stc_pkg::OP_PLANE, 32'h00020000, 32'h00030000, 32'h00010000,
                      0, 0, 0, 31'd0, 0, 0, 32'h00010000));
    send_hit(make_hit(stc_pkg::OP_PLANE, 32'h00020000, 32'hfffd0000, 32'h00010000,
                      0, 0, 0, 31'd0, 0, 0, 32'h80000000));
    // plain axis normals
    send_hit(make_hit(stc_pkg::OP_PLANE, 32'h00020000, 32'h00030000, 32'h00040000,
                      0, 0, 0, 31'd0, 32'h00010000, 0, 0));
    send_hit(make_hit(stc_pkg::OP_PLANE, 32'h00020000, 32'h00030000, 32'h00040000,
                      32'h00001000, 0, 0, 31'd0, 0, 32'hffff0000, 0));
    // saturation in both directions
    send_hit(make_hit(stc_pkg::OP_PLANE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff,
                      32'h80000000, 32'h80000000, 32'h80000000));
    send_hit(make_hit(stc_pkg::OP_PLANE, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'd0,
                      32'h7fffffff, 32'h80000000, 32'h7fffffff));
    // rounding half way points
    send_hit(make_hit(stc_pkg::OP_PLANE, 32'h00008000, 32'h00008000, 0, 0, 0, 0, 31'd0,
                      0, 1, 0));
    send_hit(make_hit(stc_pkg::OP_PLANE, 32'hffff8000, 1, 32'hffffffff, 0, 0, 0, 31'd0,
                      1, 32'hffffffff, 1));
  endtask

  task automatic test_sphere_random(int count);
    stc_pkg::in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = make_hit(stc_pkg::OP_SPHERE, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), 31'($urandom), $urandom,
                    $urandom, $urandom);
      // keep most points near the surface so acos sees interior arguments
      if ($urandom_range(0, 3) != 0)
        it.radius = 31'($urandom_range(1, 32'h00040000));
      send_hit(it);
    end
  endtask

  task automatic test_plane_random(int count);
    stc_pkg::in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = make_hit(stc_pkg::OP_PLANE, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), 31'($urandom),
                    rand_coord(), rand_coord(), rand_coord());
      // now and then put the normal on the z axis or zero it
      case ($urandom_range(0, 7))
        0: begin it.normal_x = 0; it.normal_y = 0; end
        1: begin it.normal_x = 0; it.normal_y = 0; it.normal_z = 0; end
        default: ;
      endcase
      send_hit(it);
    end
  endtask

  // mixed kinds with no idling on either side, full rate
  task automatic test_full_rate(int count);
    no_gaps = 1'b1;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) != 0) test_sphere_random(1);
      else test_plane_random(1);
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int drain;
    no_gaps        = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    rst_ni         = 1'b0;
    hit_ch.valid   = 1'b0;
    hit_ch.data    = '0;
    uv_ch.ready    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sphere_corners();
    test_plane_corners();
    test_sphere_random(260);
    test_plane_random(240);
    test_full_rate(130);
    hit_ch.valid <= 1'b0;

    // drain: every expectation met, then quiet cycles to catch any stray beat
    drain = 0;
    while (uv_expected.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (150) @(posedge clk_i);
    if (mismatch_count == 0 && uv_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/stc_pkg.sv
hdl/stc_chan_if.sv
hdl/stc_cordic_cell.sv
hdl/stc_sqrt_cell.sv
hdl/stc_delay.sv
hdl/stc_atan2.sv
hdl/surface_texture_coordinate_unit.sv
test/tb_top.sv
